[hdl/ulbc_pkg.sv]
`default_nettype none

package ulbc_pkg;

    // store sizes
    localparam int TX_DEPTH = 256;
    localparam int RX_DEPTH = 128;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

    // limits as 9-bit values for compares against counts and indexes
    localparam logic [8:0] TX_DEPTH_W = 9'(TX_DEPTH);
    localparam logic [8:0] RX_DEPTH_W = 9'(RX_DEPTH);
    localparam logic [8:0] RX_LAST_W  = 9'(RX_DEPTH - 1);

    // line terminators and the closing zero
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    // item kinds
    typedef enum logic [2:0] {
        KIND_TX_FILL   = 3'd0,
        KIND_TX_START  = 3'd1,
        KIND_TX_READY  = 3'd2,
        KIND_RX_ARM    = 3'd3,
        KIND_RX_BYTE   = 3'd4,
        KIND_ERR_RESET = 3'd5,
        KIND_RX_READ   = 3'd6
    } t_kind;

    // receive phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BUSY  = 2'd1,
        PH_ERROR = 2'd2
    } t_phase;

    // receive error codes
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_OVERRUN = 3'd1,
        ERR_FRAMING = 3'd2,
        ERR_PARITY  = 3'd3,
        ERR_NOISE   = 3'd4
    } t_err;

    // input beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] index;
        logic [7:0] data_byte;
        logic [8:0] tx_length;
        logic       err_overrun;
        logic       err_framing;
        logic       err_noise;
        logic       err_parity;
    } t_in;

    // output beat
    typedef struct packed {
        logic       rejected;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_busy;
        logic [1:0] rx_mode;
        logic [2:0] error_code;
        logic       line_done;
        logic [7:0] line_length;
        logic       rx_overflow;
        logic [7:0] read_data;
    } t_out;

    // result waiting for store read data
    typedef struct packed {
        logic       rejected;
        logic       tx_valid;
        logic       tx_busy;
        logic [1:0] rx_mode;
        logic [2:0] error_code;
        logic       line_done;
        logic [7:0] line_length;
        logic       rx_overflow;
        logic       rd_sel;
        logic       rd_zero;
    } t_stage;

endpackage

`default_nettype wire

[hdl/uart_line_buffer_controller.sv]
`default_nettype none

// channel   direction  handshake                  beat
// in        sink       i_in_valid / o_in_stall    i_in  (t_in)
// out       source     o_out_valid / i_out_stall  o_out (t_out)
//
// one beat per cycle sustained while i_out_stall stays low; each result passes
// the registered store read and then the output register.
// synchronous active-low reset clears the control state except r_nul_addr; the
// stores hold garbage until written.
// o_in_stall rises only when the read stage is full and the output register
// is held by i_out_stall; store read data stays put while stalled.
module uart_line_buffer_controller
    import ulbc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    // control and scalar state
    logic [8:0]       r_tx_count,  n_tx_count;
    logic [8:0]       r_tx_pos,    n_tx_pos;
    logic             r_tx_active, n_tx_active;
    logic [7:0]       r_line_pos,  n_line_pos;
    t_phase           r_rx_phase,  n_rx_phase;
    t_err             r_last_err,  n_last_err;
    logic             r_nul_pend,  n_nul_pend;
    logic [RX_AW-1:0] r_nul_addr,  n_nul_addr;

    // pipeline registers
    logic   r_s1_valid, n_s1_valid;
    t_stage r_s1,       n_s1;
    logic   r_out_valid;
    t_out   r_out,      n_out;

    // store ports
    logic             tx_we, tx_re;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [7:0]       tx_rdata;
    logic             rx_we, rx_re;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [7:0]       rx_wdata, rx_rdata;

    logic acc, s1_adv, any_err;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;
    assign any_err    = i_in.err_overrun || i_in.err_framing
                     || i_in.err_parity || i_in.err_noise;

    ulbc_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_in.data_byte),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    ulbc_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    // item decode, state update and store access
    always_comb begin
        n_tx_count  = r_tx_count;
        n_tx_pos    = r_tx_pos;
        n_tx_active = r_tx_active;
        n_line_pos  = r_line_pos;
        n_rx_phase  = r_rx_phase;
        n_last_err  = r_last_err;
        n_nul_pend  = 1'b0;
        n_nul_addr  = r_nul_addr;

        tx_we    = 1'b0;
        tx_waddr = i_in.index[TX_AW-1:0];
        tx_re    = 1'b0;
        tx_raddr = r_tx_pos[TX_AW-1:0];
        rx_re    = 1'b0;
        rx_raddr = i_in.index[RX_AW-1:0];

        // pending zero byte goes out unless a received byte wins the port
        rx_we    = r_nul_pend;
        rx_waddr = r_nul_addr;
        rx_wdata = CH_NUL;

        n_s1          = '0;
        n_s1.rejected = 1'b0;

        if (acc) begin
            case (i_in.kind)
                KIND_TX_FILL: begin
                    if ({1'b0, i_in.index} < TX_DEPTH_W) begin
                        tx_we = 1'b1;
                    end
                end
                KIND_TX_START: begin
                    if (r_tx_active) begin
                        n_s1.rejected = 1'b1;
                    end else begin
                        n_tx_active = 1'b1;
                        n_tx_count  = (i_in.tx_length > TX_DEPTH_W) ? TX_DEPTH_W
                                                                     : i_in.tx_length;
                        n_tx_pos    = '0;
                    end
                end
                KIND_TX_READY: begin
                    if (r_tx_active) begin
                        if (r_tx_pos < r_tx_count && r_tx_pos < TX_DEPTH_W) begin
                            tx_re         = 1'b1;
                            n_s1.tx_valid = 1'b1;
                            n_tx_pos      = r_tx_pos + 9'd1;
                        end else begin
                            n_tx_active = 1'b0;
                        end
                    end
                end
                KIND_RX_ARM: begin
                    if (r_rx_phase != PH_IDLE) begin
                        n_s1.rejected = 1'b1;
                    end else begin
                        n_rx_phase = PH_BUSY;
                        n_line_pos = '0;
                    end
                end
                KIND_RX_BYTE: begin
                    if (r_rx_phase == PH_BUSY) begin
                        if (any_err) begin
                            n_rx_phase = PH_ERROR;
                            if (i_in.err_overrun) begin
                                n_last_err = ERR_OVERRUN;
                            end else if (i_in.err_framing) begin
                                n_last_err = ERR_FRAMING;
                            end else if (i_in.err_parity) begin
                                n_last_err = ERR_PARITY;
                            end else begin
                                n_last_err = ERR_NOISE;
                            end
                        end else begin
                            n_last_err = ERR_NONE;
                            if ({1'b0, r_line_pos} < RX_LAST_W) begin
                                rx_we      = 1'b1;
                                rx_waddr   = r_line_pos[RX_AW-1:0];
                                rx_wdata   = i_in.data_byte;
                                n_line_pos = r_line_pos + 8'd1;
                                // terminator: close the line with a zero next cycle
                                if (i_in.data_byte == CH_LF || i_in.data_byte == CH_CR) begin
                                    n_nul_pend     = 1'b1;
                                    n_nul_addr     = n_line_pos[RX_AW-1:0];
                                    n_rx_phase     = PH_IDLE;
                                    n_s1.line_done = 1'b1;
                                end
                            end else begin
                                n_rx_phase       = PH_IDLE;
                                n_s1.rx_overflow = 1'b1;
                            end
                        end
                    end
                end
                KIND_ERR_RESET: begin
                    if (r_rx_phase == PH_ERROR) begin
                        n_rx_phase = PH_BUSY;
                        n_last_err = ERR_NONE;
                        n_line_pos = '0;
                    end
                end
                KIND_RX_READ: begin
                    if ({1'b0, i_in.index} < RX_DEPTH_W) begin
                        rx_re        = 1'b1;
                        n_s1.rd_sel  = 1'b1;
                        // zero byte being written this cycle is forwarded
                        n_s1.rd_zero = r_nul_pend && (rx_raddr == r_nul_addr);
                    end
                end
                default: begin
                end
            endcase
        end

        n_s1.tx_busy     = n_tx_active;
        n_s1.rx_mode     = n_rx_phase;
        n_s1.error_code  = n_last_err;
        n_s1.line_length = n_line_pos;

        n_s1_valid = acc ? 1'b1 : (s1_adv ? 1'b0 : r_s1_valid);
    end

    // merge store data into the result
    always_comb begin
        n_out             = '0;
        n_out.rejected    = r_s1.rejected;
        n_out.tx_valid    = r_s1.tx_valid;
        n_out.tx_byte     = r_s1.tx_valid ? tx_rdata : 8'd0;
        n_out.tx_busy     = r_s1.tx_busy;
        n_out.rx_mode     = r_s1.rx_mode;
        n_out.error_code  = r_s1.error_code;
        n_out.line_done   = r_s1.line_done;
        n_out.line_length = r_s1.line_length;
        n_out.rx_overflow = r_s1.rx_overflow;
        n_out.read_data   = (r_s1.rd_sel && !r_s1.rd_zero) ? rx_rdata : 8'd0;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_count  <= '0;
            r_tx_pos    <= '0;
            r_tx_active <= 1'b0;
            r_line_pos  <= '0;
            r_rx_phase  <= PH_IDLE;
            r_last_err  <= ERR_NONE;
            r_nul_pend  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tx_count  <= n_tx_count;
            r_tx_pos    <= n_tx_pos;
            r_tx_active <= n_tx_active;
            r_line_pos  <= n_line_pos;
            r_rx_phase  <= n_rx_phase;
            r_last_err  <= n_last_err;
            r_nul_pend  <= n_nul_pend;
            r_s1_valid  <= n_s1_valid;
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_nul_addr <= n_nul_addr;
        if (acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

[hdl/ulbc_ram.sv]
`default_nettype none

module ulbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/ulbc_checker.sv]
`default_nettype none

module ulbc_checker
    import ulbc_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out
);

    // a stalled output beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a sent byte only comes while a send is running
    a_tx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.tx_valid |-> o_out.tx_busy)
        else $error("tx byte without active send");

    // no byte value without tx_valid
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.tx_valid |-> o_out.tx_byte == 8'd0)
        else $error("tx byte nonzero while not valid");

    // a finished or overflowed line leaves the receiver idle
    a_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.line_done || o_out.rx_overflow)
            |-> o_out.rx_mode == PH_IDLE)
        else $error("line ended but receiver not idle");

    // a recorded error code means the receiver is in error
    a_err_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.error_code != ERR_NONE |-> o_out.rx_mode == PH_ERROR)
        else $error("error code without error state");

endmodule

bind uart_line_buffer_controller ulbc_checker u_ulbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

[tb/uart_line_buffer_controller_tb.sv]
`timescale 1ns / 1ps

module uart_line_buffer_controller_tb;
    import ulbc_pkg::*;

    localparam int         RANDOM_BEATS   = 800;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam logic [2:0] KIND_UNUSED    = 3'd7;

    // receive error flags in beat order: overrun, framing, noise, parity
    localparam logic [3:0] FL_NONE = 4'b0000;
    localparam logic [3:0] FL_FRM  = 4'b0100;
    localparam logic [3:0] FL_NOI  = 4'b0010;
    localparam logic [3:0] FL_PAR  = 4'b0001;
    localparam logic [3:0] FL_ALL  = 4'b1111;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    // mirror of the controller state
    logic [7:0] tx_copy [TX_DEPTH];
    bit         tx_copy_set [TX_DEPTH];
    logic [8:0] tx_total = '0;
    logic [8:0] tx_sent  = '0;
    logic       tx_on    = 1'b0;
    logic [7:0] line_copy [RX_DEPTH];
    bit         line_copy_set [RX_DEPTH];
    logic [7:0] line_fill = '0;
    t_phase     rx_state  = PH_IDLE;
    t_err       rx_err    = ERR_NONE;

    t_out pending_results [$];
    int   n_mismatch  = 0;
    int   beats_sent  = 0;
    int   burst_left  = 1;
    int   idle_cycles = 0;
    bit   stall_now   = 1'b0;
    int   run_left    = 0;

    uart_line_buffer_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #4 i_clk = ~i_clk;

    // advance the mirrored state by one beat and return the expected result
    function automatic t_out step_controller(input t_in b);
        t_out r;
        r = '0;
        case (b.kind)
            KIND_TX_FILL: begin
                if (b.index < TX_DEPTH) begin
                    tx_copy[b.index]     = b.data_byte;
                    tx_copy_set[b.index] = 1'b1;
                end
            end
            KIND_TX_START: begin
                if (tx_on) begin
                    r.rejected = 1'b1;
                end else begin
                    tx_on    = 1'b1;
                    tx_total = (b.tx_length > TX_DEPTH) ? 9'(TX_DEPTH) : b.tx_length;
                    tx_sent  = '0;
                end
            end
            KIND_TX_READY: begin
                if (tx_on) begin
                    if (tx_sent < tx_total && tx_sent < TX_DEPTH) begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = tx_copy[tx_sent[7:0]];
                        tx_sent    = tx_sent + 9'd1;
                    end else begin
                        tx_on = 1'b0;
                    end
                end
            end
            KIND_RX_ARM: begin
                if (rx_state != PH_IDLE) begin
                    r.rejected = 1'b1;
                end else begin
                    rx_state  = PH_BUSY;
                    line_fill = '0;
                end
            end
            KIND_RX_BYTE: begin
                if (rx_state == PH_BUSY) begin
                    if (b.err_overrun | b.err_framing | b.err_parity | b.err_noise) begin
                        rx_state = PH_ERROR;
                        if (b.err_overrun)      rx_err = ERR_OVERRUN;
                        else if (b.err_framing) rx_err = ERR_FRAMING;
                        else if (b.err_parity)  rx_err = ERR_PARITY;
                        else                    rx_err = ERR_NOISE;
                    end else begin
                        rx_err = ERR_NONE;
                        if (line_fill < RX_DEPTH - 1) begin
                            line_copy[line_fill[RX_AW-1:0]]     = b.data_byte;
                            line_copy_set[line_fill[RX_AW-1:0]] = 1'b1;
                            line_fill                           = line_fill + 8'd1;
                            if (b.data_byte == CH_LF || b.data_byte == CH_CR) begin
                                line_copy[line_fill[RX_AW-1:0]]     = CH_NUL;
                                line_copy_set[line_fill[RX_AW-1:0]] = 1'b1;
                                rx_state                            = PH_IDLE;
                                r.line_done                         = 1'b1;
                            end
                        end else begin
                            rx_state      = PH_IDLE;
                            r.rx_overflow = 1'b1;
                        end
                    end
                end
            end
            KIND_ERR_RESET: begin
                if (rx_state == PH_ERROR) begin
                    rx_state  = PH_BUSY;
                    rx_err    = ERR_NONE;
                    line_fill = '0;
                end
            end
            KIND_RX_READ: begin
                if (b.index < RX_DEPTH) r.read_data = line_copy[b.index[RX_AW-1:0]];
            end
            default: ;
        endcase
        r.tx_busy     = tx_on;
        r.rx_mode     = rx_state;
        r.error_code  = rx_err;
        r.line_length = line_fill;
        return r;
    endfunction

    function automatic t_in beat(input logic [2:0] k, input logic [7:0] idx,
                                 input logic [7:0] dat, input logic [8:0] len,
                                 input logic [3:0] fl);
        t_in b;
        b.kind      = k;
        b.index     = idx;
        b.data_byte = dat;
        b.tx_length = len;
        {b.err_overrun, b.err_framing, b.err_noise, b.err_parity} = fl;
        return b;
    endfunction

    // beat of the given kind with every other field random
    function automatic t_in any_beat(input logic [2:0] k);
        return beat(k, 8'($urandom), 8'($urandom), 9'($urandom), 4'($urandom));
    endfunction

    function automatic string show(input t_out r);
        return $sformatf({"rej=%0d txv=%0d txb=%02h busy=%0d mode=%0d err=%0d ",
                          "done=%0d len=%0d ovf=%0d rd=%02h"},
                         r.rejected, r.tx_valid, r.tx_byte, r.tx_busy, r.rx_mode,
                         r.error_code, r.line_done, r.line_length, r.rx_overflow,
                         r.read_data);
    endfunction

    function automatic void report_bad(input string what, input t_out want,
                                       input t_out got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("mismatch at %0t (%s): expected %s, got %s", $realtime, what,
                     show(want), show(got));
    endfunction

    // compare one output beat with the oldest expectation
    task automatic check_result(input t_out got);
        t_out  want;
        string diff;
        if (pending_results.size() == 0) begin
            report_bad("no result expected", '0, got);
            return;
        end
        want = pending_results.pop_front();
        diff = "";
        if (got.rejected    !== want.rejected)    diff = {diff, " rejected"};
        if (got.tx_valid    !== want.tx_valid)    diff = {diff, " tx_valid"};
        if (got.tx_byte     !== want.tx_byte)     diff = {diff, " tx_byte"};
        if (got.tx_busy     !== want.tx_busy)     diff = {diff, " tx_busy"};
        if (got.rx_mode     !== want.rx_mode)     diff = {diff, " rx_mode"};
        if (got.error_code  !== want.error_code)  diff = {diff, " error_code"};
        if (got.line_done   !== want.line_done)   diff = {diff, " line_done"};
        if (got.line_length !== want.line_length) diff = {diff, " line_length"};
        if (got.rx_overflow !== want.rx_overflow) diff = {diff, " rx_overflow"};
        if (got.read_data   !== want.read_data)   diff = {diff, " read_data"};
        if (diff != "") report_bad({"field", diff}, want, got);
    endtask

    // drive one beat, wait for it to be taken, then maybe pause between bursts
    task automatic put_beat(input t_in b);
        int gap;
        i_in       <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(step_controller(b));
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // keep sends and reads away from store entries never written
    task automatic send_beat(input t_in b);
        t_in fill;
        if (b.kind == KIND_TX_READY && tx_on && tx_sent < tx_total
                && !tx_copy_set[tx_sent[7:0]]) begin
            fill       = any_beat(KIND_TX_FILL);
            fill.index = tx_sent[7:0];
            put_beat(fill);
        end
        if (b.kind == KIND_RX_READ && b.index < RX_DEPTH
                && !line_copy_set[b.index[RX_AW-1:0]])
            b.index = 8'($urandom_range(RX_DEPTH, 255));
        put_beat(b);
    endtask

    task automatic noise_beat();
        t_in b;
        b = any_beat(3'($urandom_range(0, 7)));
        if (b.kind == KIND_TX_START && $urandom_range(0, 3) != 0)
            b.tx_length = 9'($urandom_range(0, 12));
        if (b.kind == KIND_RX_BYTE && $urandom_range(0, 2) != 0)
            {b.err_overrun, b.err_framing, b.err_noise, b.err_parity} = FL_NONE;
        send_beat(b);
    endtask

    // fill a few bytes, start a send and clock it out to the end
    task automatic tx_sequence(input bit go_long);
        int  len;
        t_in b;
        if (go_long)                        len = $urandom_range(TX_DEPTH, 511);
        else if ($urandom_range(0, 15) == 0) len = $urandom_range(0, 511);
        else                                len = $urandom_range(0, 12);
        repeat ($urandom_range(0, 4)) begin
            b       = any_beat(KIND_TX_FILL);
            b.index = 8'($urandom_range(0, 15));
            send_beat(b);
        end
        b           = any_beat(KIND_TX_START);
        b.tx_length = 9'(len);
        send_beat(b);
        while (tx_on) begin
            if ($urandom_range(0, 5) == 0) noise_beat();
            send_beat(any_beat(KIND_TX_READY));
        end
    endtask

    // arm, receive a line with random content, close it and read some of it back
    task automatic rx_sequence(input bit go_long);
        int  n;
        int  i;
        t_in b;
        if (rx_state == PH_ERROR) send_beat(any_beat(KIND_ERR_RESET));
        else                      send_beat(any_beat(KIND_RX_ARM));
        if (go_long)                         n = RX_DEPTH + 2;
        else if ($urandom_range(0, 19) == 0) n = $urandom_range(RX_DEPTH - 8, RX_DEPTH + 8);
        else                                 n = $urandom_range(0, 10);
        i = 0;
        while (i < n && rx_state == PH_BUSY) begin
            b = any_beat(KIND_RX_BYTE);
            if (b.data_byte == CH_LF || b.data_byte == CH_CR)
                b.data_byte = b.data_byte ^ 8'h40;
            if (n > 10 || $urandom_range(0, 24) != 0)
                {b.err_overrun, b.err_framing, b.err_noise, b.err_parity} = FL_NONE;
            if (n <= 10 && $urandom_range(0, 7) == 0) noise_beat();
            send_beat(b);
            i++;
        end
        if (rx_state == PH_BUSY) begin
            b           = any_beat(KIND_RX_BYTE);
            b.data_byte = $urandom_range(0, 1) ? CH_CR : CH_LF;
            {b.err_overrun, b.err_framing, b.err_noise, b.err_parity} = FL_NONE;
            send_beat(b);
        end
        repeat ($urandom_range(0, 4)) begin
            b       = any_beat(KIND_RX_READ);
            b.index = 8'($urandom_range(0, line_fill + 1));
            send_beat(b);
        end
    endtask

    task automatic test_transmit_send();
        // ready with no send in progress
        send_beat(any_beat(KIND_TX_READY));
        send_beat(beat(KIND_TX_FILL, 8'd0, 8'hFF, 9'd0, FL_NONE));
        send_beat(beat(KIND_TX_FILL, 8'd1, 8'h00, 9'd0, FL_NONE));
        send_beat(beat(KIND_TX_FILL, 8'd255, 8'h5A, 9'h1FF, FL_ALL));
        send_beat(beat(KIND_TX_START, 8'd0, 8'd0, 9'd2, FL_NONE));
        // start while sending, longest length
        send_beat(beat(KIND_TX_START, 8'hFF, 8'hFF, 9'h1FF, FL_NONE));
        send_beat(beat(KIND_TX_READY, 8'hFF, 8'hFF, 9'h1FF, FL_ALL));
        // overwrite a byte that is still to go out
        send_beat(beat(KIND_TX_FILL, 8'd1, 8'h3C, 9'd0, FL_NONE));
        send_beat(any_beat(KIND_TX_READY));
        send_beat(any_beat(KIND_TX_READY));
    endtask

    task automatic test_receive_line();
        // byte and error reset while not armed are ignored
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'h41, 9'd0, FL_ALL));
        send_beat(any_beat(KIND_ERR_RESET));
        send_beat(any_beat(KIND_RX_ARM));
        send_beat(any_beat(KIND_RX_ARM));
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'hFF, 9'd0, FL_NONE));
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'h00, 9'd0, FL_NONE));
        send_beat(beat(KIND_RX_BYTE, 8'd0, CH_CR, 9'd0, FL_NONE));
        send_beat(beat(KIND_RX_READ, 8'd0, 8'd0, 9'd0, FL_NONE));
        // closing zero, then an index past the line store
        send_beat(beat(KIND_RX_READ, 8'd3, 8'd0, 9'd0, FL_NONE));
        send_beat(beat(KIND_RX_READ, 8'd255, 8'd0, 9'd0, FL_NONE));
    endtask

    task automatic test_receive_errors();
        // each flag set wins over those below it in the order overrun, framing, parity, noise
        send_beat(any_beat(KIND_RX_ARM));
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'h55, 9'd0, FL_ALL));
        send_beat(any_beat(KIND_RX_ARM));
        send_beat(any_beat(KIND_ERR_RESET));
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'h55, 9'd0, FL_FRM | FL_NOI | FL_PAR));
        send_beat(any_beat(KIND_ERR_RESET));
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'h55, 9'd0, FL_NOI | FL_PAR));
        send_beat(any_beat(KIND_ERR_RESET));
        send_beat(beat(KIND_RX_BYTE, 8'd0, 8'h55, 9'd0, FL_NOI));
        send_beat(any_beat(KIND_ERR_RESET));
        send_beat(beat(KIND_RX_BYTE, 8'd0, CH_LF, 9'd0, FL_NONE));
    endtask

    task automatic test_unknown_kind();
        send_beat(any_beat(KIND_UNUSED));
    endtask

    task automatic test_random_traffic();
        int goal;
        goal = beats_sent + RANDOM_BEATS;
        // one oversize send and one overflowing line first
        tx_sequence(1'b1);
        rx_sequence(1'b1);
        while (beats_sent < goal) begin
            case ($urandom_range(0, 5))
                0, 1:    tx_sequence(1'b0);
                2, 3:    rx_sequence(1'b0);
                default: repeat ($urandom_range(1, 4)) noise_beat();
            endcase
        end
    endtask

    // result checking and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out);
        if (run_left == 0) begin
            stall_now = !stall_now;
            if (stall_now)                     run_left = $urandom_range(1, 6);
            else if ($urandom_range(0, 3) == 0) run_left = $urandom_range(20, 80);
            else                               run_left = $urandom_range(1, 8);
        end else begin
            run_left--;
        end
        i_out_stall <= stall_now;
    end

    // watchdog on cycles without any beat taken
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_transmit_send();
        test_receive_line();
        test_receive_errors();
        test_unknown_kind();
        test_random_traffic();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[uart_line_buffer_controller.f]
hdl/ulbc_pkg.sv
hdl/ulbc_ram.sv
hdl/uart_line_buffer_controller.sv
hdl/ulbc_checker.sv
tb/uart_line_buffer_controller_tb.sv
